### rtl/lrucmc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lru cache miss classifier
// no dependencies; imported by lrucmc_cell and lru_cache_miss_classifier

package lrucmc_pkg;

    localparam int CAP_W      = 5;
    localparam int TOTAL_W    = 32;
    localparam int OUTCOME_W  = 2;
    localparam int CELL_IDX_W = 6;

    localparam logic [OUTCOME_W-1:0] OUT_HIT        = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COMPULSORY = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_CAPACITY   = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    typedef struct packed
    {
        logic commit;
        logic miss;
    } cell_ctrl_t;

endpackage

### rtl/lrucmc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module lrucmc_ram
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/lrucmc_cell.sv
`timescale 1ns / 1ps
// one position of the recency stack: holds a tag and its valid bit
// depends on lrucmc_pkg

module lrucmc_cell
#(
    parameter int TAG_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lrucmc_pkg::cell_ctrl_t    ctrl,
    input  logic                      keep,
    input  logic [TAG_BITS-1:0]       look_tag,
    input  logic [TAG_BITS-1:0]       prev_tag,
    input  logic                      prev_valid,
    input  logic                      any_in,
    output logic                      any_out,
    output logic                      match,
    output logic [TAG_BITS-1:0]       tag,
    output logic                      valid
);

    import lrucmc_pkg::*;

    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic                valid_reg;
    logic                valid_next;
    logic                shift;

    assign match   = valid_reg && (tag_reg == look_tag);
    assign any_out = match || any_in;
    // this cell and all above it move down one place on a miss or when the hit lies here or deeper
    assign shift   = ctrl.miss || any_out;

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (ctrl.commit)
        begin
            if (shift)
            begin
                tag_next   = prev_tag;
                valid_next = prev_valid && keep;
            end
            else
            begin
                valid_next = valid_reg && keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;

endmodule

### rtl/lru_cache_miss_classifier.sv
`timescale 1ns / 1ps
// lru cache miss classifier: row of recency cells plus a seen-map ram
// flow: an accepted access moves idle to look while the seen-map ram read is registered;
// the commit in look, held while the output stalls, registers the result; no new access
// is taken until the last one commits, as the registered seen-map read comes ahead of the cell row update
// reset: clears cells and counts, sets capacity to 16, then sweeps all 2**TAG_BITS seen-map
// entries (1024 by default) with in_stall high; config still taken

module lru_cache_miss_classifier
#(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrucmc_pkg::CAP_W-1:0]        capacity_entries,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [TAG_BITS-1:0]                 access_tag,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lrucmc_pkg::OUTCOME_W-1:0]    outcome,
    output logic [lrucmc_pkg::TOTAL_W-1:0]      compulsory_total,
    output logic [lrucmc_pkg::TOTAL_W-1:0]      capacity_total
);

    import lrucmc_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [TAG_BITS-1:0]  clr_reg;
    logic [TAG_BITS-1:0]  clr_next;
    logic [TAG_BITS-1:0]  look_tag_reg;
    logic [TOTAL_W-1:0]   comp_reg;
    logic [TOTAL_W-1:0]   comp_next;
    logic [TOTAL_W-1:0]   capm_reg;
    logic [TOTAL_W-1:0]   capm_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [OUTCOME_W-1:0] outcome_next;

    logic                 accept;
    logic                 commit;
    logic                 hit;
    logic                 seen;
    cell_ctrl_t           ctrl;

    logic [TAG_BITS-1:0]  tag_q [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] keep_vec;
    logic [MAX_ENTRIES:0]   any_vec;

    logic                 ram_wr_en;
    logic [TAG_BITS-1:0]  ram_wr_addr;
    logic                 ram_wr_data;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign commit    = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);
    assign hit       = any_vec[0];
    assign ctrl      = '{commit: commit, miss: !hit};
    assign in_stall  = (state_reg != ST_IDLE);

    // cell row
    assign any_vec[MAX_ENTRIES] = 1'b0;

    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        logic [TAG_BITS-1:0] prev_tag;
        logic                prev_valid;

        // a zero capacity acts as one entry
        assign keep_vec[k] = (k == 0) || (CELL_IDX_W'(k) < {1'b0, cap_reg});

        if (k == 0)
        begin : g_head
            assign prev_tag   = look_tag_reg;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_tag   = tag_q[k-1];
            assign prev_valid = valid_vec[k-1];
        end

        lrucmc_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .keep       (keep_vec[k]),
            .look_tag   (look_tag_reg),
            .prev_tag   (prev_tag),
            .prev_valid (prev_valid),
            .any_in     (any_vec[k+1]),
            .any_out    (any_vec[k]),
            .match      (match_vec[k]),
            .tag        (tag_q[k]),
            .valid      (valid_vec[k])
        );
    end

    // seen map
    assign ram_wr_en   = (state_reg == ST_CLEAR) || commit;
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : look_tag_reg;
    assign ram_wr_data = (state_reg == ST_LOOK);

    lrucmc_ram #(
        .WIDTH (1),
        .DEPTH (2 ** TAG_BITS)
    ) u_seen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (access_tag),
        .rd_data (seen)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        comp_next      = comp_reg;
        capm_next      = capm_reg;
        out_valid_next = out_valid_reg;
        outcome_next   = outcome_reg;

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    priority if (hit)
                    begin
                        outcome_next = OUT_HIT;
                    end
                    else if (seen)
                    begin
                        outcome_next = OUT_CAPACITY;
                        if (capm_reg != '1)
                        begin
                            capm_next = capm_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        outcome_next = OUT_COMPULSORY;
                        if (comp_reg != '1)
                        begin
                            comp_next = comp_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cap_reg       <= CAP_RESET;
            comp_reg      <= '0;
            capm_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            comp_reg      <= comp_next;
            capm_reg      <= capm_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_entries;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            look_tag_reg <= access_tag;
        end
        outcome_reg <= outcome_next;
    end

    assign out_valid        = out_valid_reg;
    assign outcome          = outcome_reg;
    assign compulsory_total = comp_reg;
    assign capacity_total   = capm_reg;

    // resident tags are distinct
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
    else $error("more than one cell matches the lookup tag");

    // valid cells always form a run from the most recent position
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("gap in the valid cells");

    // after an update no entry lies beyond the capacity, unless a capacity write came with it
    a_cap_trim: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> ((valid_vec & ~keep_vec) == '0) || $past(cfg_valid))
    else $error("entries beyond capacity after update");

    // every update presents a result and fills the most recent cell
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && valid_vec[0])
    else $error("update without result");

endmodule

### tb/sv/tb_lru_cache_miss_classifier.sv
`timescale 1ns / 1ps
// self-checking testbench for lru_cache_miss_classifier: directed and random access tags,
// capacity rewritten between phases, results checked against an lru recency predictor
// depends on lrucmc_pkg and the lru_cache_miss_classifier rtl

module tb_lru_cache_miss_classifier;

    import lrucmc_pkg::*;

    localparam int NUM_ENTRIES    = 16;
    localparam int TAG_W          = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 27;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int PHASE_ITEMS    = 70;

    typedef struct packed
    {
        logic [OUTCOME_W-1:0] outcome;
        logic [TOTAL_W-1:0]   compulsory_total;
        logic [TOTAL_W-1:0]   capacity_total;
    } access_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     capacity_entries;
    logic                 in_valid;
    logic                 in_stall;
    logic [TAG_W-1:0]     access_tag;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUTCOME_W-1:0] outcome;
    logic [TOTAL_W-1:0]   compulsory_total;
    logic [TOTAL_W-1:0]   capacity_total;

    // predictor state
    logic [TAG_W-1:0] lru_tags [NUM_ENTRIES];
    int               lru_depth = 0;
    bit               tag_seen [1 << TAG_W];
    logic [TOTAL_W-1:0] first_touch_count = '0;
    logic [TOTAL_W-1:0] refetch_count = '0;
    logic [CAP_W-1:0] capacity_setting = CAP_RESET;

    logic [TAG_W-1:0] pending_tags [$];
    access_result_t   predicted_outcomes [$];
    logic             tag_moved = 1'b0;
    bit               calm = 1'b0;
    int               mismatches = 0;
    int               results_seen = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    int               quiet_cycles = 0;

    lru_cache_miss_classifier
    #(
        .MAX_ENTRIES(NUM_ENTRIES),
        .TAG_BITS(TAG_W)
    )
    uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .capacity_entries(capacity_entries),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .access_tag(access_tag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .outcome(outcome),
        .compulsory_total(compulsory_total),
        .capacity_total(capacity_total)
    );

    function automatic access_result_t classify_access(input logic [TAG_W-1:0] tag);
        access_result_t res;
        int limit;
        int hit_at;
        int grown;
        if (capacity_setting == 0)
            limit = 1;
        else if (capacity_setting > NUM_ENTRIES)
            limit = NUM_ENTRIES;
        else
            limit = int'(capacity_setting);
        hit_at = -1;
        for (int k = 0; k < lru_depth; k++)
            if (hit_at < 0 && lru_tags[k] == tag)
                hit_at = k;
        if (hit_at >= 0)
        begin
            for (int k = hit_at; k > 0; k--)
                lru_tags[k] = lru_tags[k-1];
            lru_tags[0] = tag;
            res.outcome = OUT_HIT;
        end
        else
        begin
            grown = (lru_depth < NUM_ENTRIES) ? lru_depth + 1 : NUM_ENTRIES;
            for (int k = grown - 1; k > 0; k--)
                lru_tags[k] = lru_tags[k-1];
            lru_tags[0] = tag;
            lru_depth = grown;
            if (tag_seen[tag])
            begin
                res.outcome = OUT_CAPACITY;
                if (refetch_count != '1)
                    refetch_count++;
            end
            else
            begin
                res.outcome = OUT_COMPULSORY;
                if (first_touch_count != '1)
                    first_touch_count++;
            end
        end
        tag_seen[tag] = 1'b1;
        if (lru_depth > limit)
            lru_depth = limit;
        res.compulsory_total = first_touch_count;
        res.capacity_total = refetch_count;
        return res;
    endfunction

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        capacity_entries <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (pending_tags.size() != 0 || in_valid || predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // access driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || tag_moved)
        begin
            if (pending_tags.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                access_tag <= pending_tags[0];
                pending_tags.delete(0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : check_results
        access_result_t want;
        if (rst_n)
        begin
            tag_moved <= in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
                capacity_setting = capacity_entries;
            if (in_valid && !in_stall)
                predicted_outcomes.insert(predicted_outcomes.size(),
                                          classify_access(access_tag));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (predicted_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing pending: outcome %0d", outcome);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outcomes[0];
                    predicted_outcomes.delete(0);
                    if (outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                        mismatches++;
                    end
                    if (compulsory_total !== want.compulsory_total)
                    begin
                        $error("compulsory_total: expected %0d, got %0d",
                               want.compulsory_total, compulsory_total);
                        mismatches++;
                    end
                    if (capacity_total !== want.capacity_total)
                    begin
                        $error("capacity_total: expected %0d, got %0d",
                               want.capacity_total, capacity_total);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [CAP_W-1:0] phase_caps [10];
        logic [TAG_W-1:0] base;
        int               spread;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        capacity_entries = '0;
        in_valid = 1'b0;
        access_tag = '0;
        out_stall = 1'b0;
        phase_caps = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd0, 5'd17, 5'd8, 5'd12, 5'd2, 5'd0};
        phase_caps[9] = CAP_W'($urandom_range(31));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset capacity: extremes of the tag, then hits on both
        pending_tags = '{10'd0, 10'd1023, 10'd0, 10'd1023};
        drain_results();
        // capacity lowered, evicted tags come back as capacity misses
        write_capacity(5'd2);
        pending_tags = '{10'd5, 10'd0, 10'd1023, 10'd1023};
        drain_results();
        // zero capacity behaves as a single entry
        write_capacity(5'd0);
        pending_tags = '{10'd1023, 10'd5, 10'd5, 10'd1023};
        drain_results();
        write_capacity(5'd3);
        pending_tags = '{10'd7, 10'd8, 10'd9, 10'd7, 10'd6, 10'd8};
        drain_results();
        // capacity dropped below occupancy: all residents still searched once
        write_capacity(5'd1);
        pending_tags = '{10'd7, 10'd6};
        drain_results();

        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            calm = (p == 6);
            base = TAG_W'($urandom_range(1023));
            spread = $urandom_range(24, 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 15)
                    pending_tags.insert(pending_tags.size(), TAG_W'($urandom_range(1023)));
                else
                    pending_tags.insert(pending_tags.size(),
                                        TAG_W'(base + $urandom_range(spread)));
            end
            drain_results();
        end
        calm = 1'b0;
        repeat (8) @(posedge clk);

        if (mismatches == 0 && predicted_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/lrucmc_pkg.sv
rtl/lrucmc_ram.sv
rtl/lrucmc_cell.sv
rtl/lru_cache_miss_classifier.sv
tb/sv/tb_lru_cache_miss_classifier.sv
